FILE: hdl/mavg_pkg.sv
package mavg_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WSIZE_W    = 7;

  localparam logic [SAMPLE_W-1:0] UPPER_RST = '1;
  localparam logic [SAMPLE_W-1:0] LOWER_RST = '0;
  localparam int                  WSIZE_RST = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1,
    REG_WSIZE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CHECK  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 opcode;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                stop_command;
    logic [SAMPLE_W-1:0] mean_current;
  } out_item_t;

endpackage

FILE: hdl/moving_average_overcurrent_detector.sv
// Moving-average over-current detector. A sample transfer writes the reading
// into a ring held in a one-port-write, one-port-read memory and adds it to a
// running sum; once the window holds window_size readings the mean becomes
// sum / window_size, computed by a 16-step serial divider, and the oldest
// reading, read back from the memory, leaves the sum. A check transfer
// compares the mean with the upper bound. Every transfer gives exactly one
// result. No new item is accepted until its result is registered: a check
// goes straight to output, a sample first reads the oldest reading and, if
// it fills the window, runs the divider; a stalled receiver holds it off.
// The ring memory needs no clearing pass after reset. Configuration is
// accepted while no item is in flight, and a pending register write holds
// the input off.
module moving_average_overcurrent_detector
  import mavg_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int EW    = (NW > WSIZE_W) ? NW : WSIZE_W;
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam logic [NW-1:0] N_RST =
    NW'((MAX_WINDOW < WSIZE_RST) ? MAX_WINDOW : WSIZE_RST);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic [SAMPLE_W-1:0] upper_q;
  logic [SAMPLE_W-1:0] lower_q;
  logic [NW-1:0]       n_q;
  logic [AW-1:0]       head_q;
  logic [NW-1:0]       fill_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] mean_q;
  logic [SAMPLE_W-1:0] s_q;
  logic [SAMPLE_W-1:0] oldest_q;
  logic                stop_q;
  logic                out_valid_q;
  out_item_t           out_data_q;

  logic                in_acc;
  logic                cfg_acc;
  logic                mem_we;
  logic [AW-1:0]       slot;
  logic [NW:0]         slot_sum;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic                full;
  logic [EW-1:0]       ws_ext;
  logic [NW-1:0]       n_new;
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] quotient;

  // a pending register write goes first
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign mem_we      = in_acc && (in_data_i.opcode == OP_SAMPLE);
  assign div_start   = (state_q == ST_READ) && full;

  always_comb begin
    // head and fill are both below the depth, so one wrap is enough
    slot_sum = {1'b0, NW'(head_q)} + {1'b0, fill_q};
    if (slot_sum >= (NW + 1)'(MAX_WINDOW)) begin
      slot = AW'(slot_sum - (NW + 1)'(MAX_WINDOW));
    end else begin
      slot = AW'(slot_sum);
    end
    full = ((fill_q + 1'b1) >= n_q);
    // window size zero acts as one, above the depth it saturates
    ws_ext = EW'(cfg_data_i[WSIZE_W-1:0]);
    if (ws_ext == '0) begin
      n_new = NW'(1);
    end else if (ws_ext > EW'(MAX_WINDOW)) begin
      n_new = NW'(MAX_WINDOW);
    end else begin
      n_new = NW'(ws_ext);
    end
  end

  mavg_win_mem #(
    .DEPTH  (MAX_WINDOW),
    .AW     (AW),
    .DATA_W (SAMPLE_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot),
    .wdata_i (in_data_i.sample),
    .re_i    (mem_we),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  mavg_div #(
    .SUM_W (SUM_W),
    .NW    (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upper_q     <= UPPER_RST;
      lower_q     <= LOWER_RST;
      n_q         <= N_RST;
      head_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      mean_q      <= LOWER_RST;
      s_q         <= '0;
      oldest_q    <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_UPPER: begin
            upper_q <= cfg_data_i[SAMPLE_W-1:0];
          end
          REG_LOWER: begin
            lower_q <= cfg_data_i[SAMPLE_W-1:0];
            mean_q  <= cfg_data_i[SAMPLE_W-1:0];
          end
          REG_WSIZE: begin
            n_q    <= n_new;
            head_q <= '0;
            fill_q <= '0;
            sum_q  <= '0;
            mean_q <= lower_q;
          end
          default: begin
          end
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data_i.opcode == OP_CHECK) begin
              stop_q  <= (mean_q > upper_q);
              state_q <= ST_OUT;
            end else begin
              stop_q  <= 1'b0;
              s_q     <= in_data_i.sample;
              sum_q   <= sum_q + SUM_W'(in_data_i.sample);
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          // with an empty ring the oldest entry is the one just written
          oldest_q <= (fill_q == '0) ? s_q : mem_rdata;
          if (full) begin
            state_q <= ST_DIV;
          end else begin
            fill_q  <= fill_q + 1'b1;
            state_q <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            mean_q <= quotient;
            sum_q  <= sum_q - SUM_W'(oldest_q);
            if (head_q == AW'(MAX_WINDOW - 1)) begin
              head_q <= '0;
            end else begin
              head_q <= head_q + 1'b1;
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q             <= 1'b1;
            out_data_q.stop_command <= stop_q;
            out_data_q.mean_current <= mean_q;
            state_q                 <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/mavg_win_mem.sv
module mavg_win_mem #(
  parameter int DEPTH  = 64,
  parameter int AW     = 6,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mavg_div.sv
module mavg_div
  import mavg_pkg::*;
#(
  parameter int SUM_W = 22,
  parameter int NW    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SUM_W-1:0]    dividend_i,
  input  logic [NW-1:0]       divisor_i,
  output logic                done_o,
  output logic [SAMPLE_W-1:0] quotient_o
);

  localparam int CW = $clog2(SAMPLE_W);

  logic                busy_q;
  logic                done_q;
  logic [CW-1:0]       cnt_q;
  logic [NW-1:0]       rem_q;
  logic [NW-1:0]       rem_d;
  logic [SAMPLE_W-1:0] dq_q;
  logic [NW:0]         trial;
  logic                qbit;

  // restoring division, one quotient bit per cycle; the quotient shifts in
  // behind the low dividend bits
  always_comb begin
    trial = {rem_q, dq_q[SAMPLE_W-1]};
    qbit  = (trial >= {1'b0, divisor_i});
    rem_d = qbit ? NW'(trial - {1'b0, divisor_i}) : NW'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dq_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= NW'(dividend_i >> SAMPLE_W);
        dq_q   <= dividend_i[SAMPLE_W-1:0];
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        rem_q <= rem_d;
        dq_q  <= {dq_q[SAMPLE_W-2:0], qbit};
        if (cnt_q == CW'(SAMPLE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: hdl/mavg_checker.sv
module mavg_checker
  import mavg_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o,
  input logic      cfg_valid_i,
  input logic      cfg_ready_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item at a time: an accepted item closes the input for the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after a transfer");

  // without a pending write, configuration is open exactly when the input is
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |-> (cfg_ready_o == !in_stall_o))
    else $error("configuration and input readiness disagree");

  // a pending write holds the input off
  a_cfg_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> in_stall_o)
    else $error("input open during a register write");

  // a stop needs a mean above some bound, so the mean cannot be zero
  a_stop_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stop_command |-> out_data_o.mean_current != '0)
    else $error("stop with zero mean");

endmodule

bind moving_average_overcurrent_detector mavg_checker u_mavg_checker (.*);

FILE: tb/moving_average_overcurrent_detector_tb.sv
module moving_average_overcurrent_detector_tb
  import mavg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WINDOW = 64;
  localparam int RANDOM_ITEMS = 750;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  class mean_scoreboard;
    logic [SAMPLE_W-1:0] upper;
    logic [SAMPLE_W-1:0] lower;
    logic [WSIZE_W-1:0]  wsize;
    logic [SAMPLE_W-1:0] ring [MAX_WINDOW];
    logic [5:0]          head;
    logic [6:0]          fill;
    logic [21:0]         sum;
    logic [SAMPLE_W-1:0] mean;
    out_item_t           expected_q[$];
    int                  errors;

    function new();
      upper  = UPPER_RST;
      lower  = LOWER_RST;
      wsize  = WSIZE_W'(WSIZE_RST);
      head   = '0;
      fill   = '0;
      sum    = '0;
      mean   = LOWER_RST;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_UPPER: upper = data;
        REG_LOWER: begin
          lower = data;
          mean  = data;
        end
        REG_WSIZE: begin
          wsize = data[WSIZE_W-1:0];
          head  = '0;
          fill  = '0;
          sum   = '0;
          mean  = lower;
        end
        default: ;
      endcase
    endfunction

    // updates the filter state and queues the result this transfer must give
    function void note_item(in_item_t it);
      out_item_t  res;
      logic [6:0] n;
      logic [5:0] slot;
      res = '0;
      if (it.opcode == OP_SAMPLE) begin
        n = (wsize == 0) ? 7'd1 : (wsize > MAX_WINDOW) ? 7'(MAX_WINDOW) : wsize;
        slot = head + fill[5:0];
        ring[slot] = it.sample;
        sum  = sum + it.sample;
        fill = fill + 1'b1;
        if (fill >= n) begin
          mean = SAMPLE_W'(sum / n);
          sum  = sum - ring[head];
          head = head + 1'b1;
          fill = fill - 1'b1;
        end
      end else begin
        res.stop_command = (mean > upper);
      end
      res.mean_current = mean;
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result stop=%0d mean=%0d", $time,
                 got.stop_command, got.mean_current);
        errors++;
        return;
      end
      exp_res = expected_q[0];
      expected_q.delete(0);
      if (got.stop_command !== exp_res.stop_command) begin
        $display("%0t: stop_command expected %0d got %0d", $time,
                 exp_res.stop_command, got.stop_command);
        errors++;
      end
      if (got.mean_current !== exp_res.mean_current) begin
        $display("%0t: mean_current expected %0d got %0d", $time,
                 exp_res.mean_current, got.mean_current);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mean_scoreboard sb = new();
  bit no_gaps;
  bit hold_req;
  bit hold_taken;

  moving_average_overcurrent_detector dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_item(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // receiver: runs of no stall, random stall, solid stall, and one long hold-off
  initial begin
    int r;
    int len;
    forever begin
      r   = $urandom_range(0, 9);
      len = $urandom_range(1, 30);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        repeat (400) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else if (r < 4) begin
        repeat (len) begin
          @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end else if (r < 8) begin
        repeat (len) begin
          @(posedge clk_i);
          out_stall_i <= ($urandom_range(0, 2) == 0);
        end
      end else begin
        repeat ($urandom_range(5, 40)) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (no_gaps || r < 5) return 0;
    if (r < 8) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(int center, int spread);
    int r;
    int v;
    r = $urandom_range(0, 15);
    if (r == 0) return SAMPLE_W'($urandom);
    if (r == 1) return ($urandom_range(0, 1) == 1) ? '1 : '0;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return SAMPLE_W'(v);
  endfunction

  // called and returns at a rising edge
  task automatic send_item(op_e op, logic [SAMPLE_W-1:0] value);
    int gap;
    in_valid_i       <= 1'b1;
    in_data_i.opcode <= op;
    in_data_i.sample <= value;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    // let the monitor note a transfer taken at the current edge
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int done;
    int phase;
    int wsize;
    int neff;
    int len;
    int center;
    int spread;
    logic [CFG_DATA_W-1:0] bound;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // mean holds lower bound until the window first fills
    send_item(OP_CHECK, 16'hFFFF);
    repeat (8) send_item(OP_SAMPLE, 16'hFFFF);
    // mean equal to upper bound gives no stop
    send_item(OP_CHECK, 16'h0000);
    write_reg(REG_UPPER, 16'h0000);
    send_item(OP_CHECK, 16'h1234);
    write_reg(REG_WSIZE, 16'h0001);
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_SAMPLE, 16'hAAAA);
    send_item(OP_SAMPLE, 16'h5555);
    send_item(OP_CHECK, 16'h0000);
    write_reg(REG_LOWER, 16'hFFFF);
    send_item(OP_CHECK, 16'h0000);
    // size zero acts as one, upper data bits are dropped
    write_reg(REG_WSIZE, 16'hFF80);
    send_item(OP_SAMPLE, 16'h1234);
    send_item(OP_SAMPLE, 16'h8000);
    // oversized window saturates, unknown index is ignored
    write_reg(REG_WSIZE, 16'h007F);
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(REG_UPPER, 16'h7FFF);
    repeat (3) send_item(OP_SAMPLE, 16'hFFFF);
    send_item(OP_CHECK, 16'h0000);

    done  = 0;
    phase = 0;
    while (done < RANDOM_ITEMS) begin
      center = $urandom_range(0, 65535);
      case ($urandom_range(0, 2))
        0:       spread = 64;
        1:       spread = 4096;
        default: spread = 65535;
      endcase
      case (phase % 6)
        0:       wsize = 1;
        1:       wsize = MAX_WINDOW;
        2:       wsize = 0;
        3:       wsize = $urandom_range(MAX_WINDOW + 1, 127);
        default: wsize = $urandom_range(1, MAX_WINDOW);
      endcase
      neff = (wsize == 0) ? 1 : (wsize > MAX_WINDOW) ? MAX_WINDOW : wsize;

      case ($urandom_range(0, 5))
        0:       bound = 16'h0000;
        1:       bound = 16'hFFFF;
        default: bound = pick_sample(center, spread / 4);
      endcase
      write_reg(REG_UPPER, bound);
      if (phase < 6 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0:       bound = 16'h0000;
          1:       bound = 16'hFFFF;
          default: bound = pick_sample(center, spread);
        endcase
        write_reg(REG_LOWER, bound);
      end
      if (phase < 6 || $urandom_range(0, 3) != 0)
        write_reg(REG_WSIZE, {9'($urandom), 7'(wsize)});
      if ($urandom_range(0, 7) == 0)
        write_reg(REG_NONE, 16'($urandom));

      no_gaps = (phase == 2) || ($urandom_range(0, 3) == 0);
      if (phase == 2) hold_req = 1'b1;
      len = 2 * neff + $urandom_range(20, 60);
      if (len > RANDOM_ITEMS - done) len = RANDOM_ITEMS - done;
      repeat (len) begin
        if ($urandom_range(0, 3) == 0) send_item(OP_CHECK, 16'($urandom));
        else send_item(OP_SAMPLE, pick_sample(center, spread));
      end
      done += len;
      phase++;
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
